// File: rtl/npps_pkg.sv
// shared constants and types for the non-preemptive priority scheduler
package npps_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    localparam int ARR_W    = 16;
    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int ID_W     = 7;
    localparam int TIME_W   = 22;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic PRIO_MODE_LARGER  = 1'b0;
    localparam logic PRIO_MODE_SMALLER = 1'b1;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } job_entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        job_entry_t       wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    // strict priority win of a over b
    function automatic logic prio_wins(input logic [PRIO_W-1:0] a,
                                       input logic [PRIO_W-1:0] b,
                                       input logic mode);
        logic res;
        if (mode == PRIO_MODE_SMALLER)
        begin
            res = (a < b);
        end
        else
        begin
            res = (a > b);
        end
        return res;
    endfunction

endpackage

// File: rtl/npps_ifs.sv
// job and result channel interfaces
interface npps_job_if;
    logic                       valid;
    logic                       ready;
    logic [npps_pkg::ARR_W-1:0]   arrival_time;
    logic [npps_pkg::BURST_W-1:0] burst_time;
    logic [npps_pkg::PRIO_W-1:0]  job_priority;
    logic                       last_job;

    modport source (output valid, arrival_time, burst_time, job_priority, last_job,
                    input ready);
    modport sink (input valid, arrival_time, burst_time, job_priority, last_job,
                  output ready);
endinterface

interface npps_result_if;
    logic                        valid;
    logic                        ready;
    logic [npps_pkg::ID_W-1:0]   job_id;
    logic [npps_pkg::TIME_W-1:0] start_time;
    logic [npps_pkg::TIME_W-1:0] finish_time;
    logic [npps_pkg::TIME_W-1:0] turnaround_time;
    logic [npps_pkg::TIME_W-1:0] waiting_time;
    logic                        last_result;

    modport source (output valid, job_id, start_time, finish_time, turnaround_time,
                    waiting_time, last_result, input ready);
    modport sink (input valid, job_id, start_time, finish_time, turnaround_time,
                  waiting_time, last_result, output ready);
endinterface

// File: rtl/nonpreemptive_priority_scheduler_top.sv
// top level of the non-preemptive priority scheduler
// Jobs are loaded one transaction per cycle into a 16-entry job table; job ids are
// load positions from 1 and jobs past the table capacity are dropped. The transaction
// flagged last_job starts a run: for every scheduled job the block sweeps the whole
// table through the single read port of the job memory. No new job is taken during a
// run; the next set can be loaded as soon as the last result is in the output register.
// priority_mode is sampled when the run starts; with mode 0 a larger number wins, with
// mode 1 a smaller one. Ties go to the earlier arrival, then to the lower id. Start and
// finish times saturate at the top of the 22-bit range.
module nonpreemptive_priority_scheduler_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    npps_job_if.sink             job,
    npps_result_if.source        result,
    input  logic                 cfg_write_en,
    input  logic                 cfg_write_data
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FINISH
    } state_t;

    localparam int IW = npps_pkg::IDX_W;
    localparam int CW = npps_pkg::CNT_W;
    localparam int TW = npps_pkg::TIME_W;

    state_t                        state_reg, state_next;
    logic                          prio_mode_reg, prio_mode_next;
    logic                          run_mode_reg, run_mode_next;
    logic [CW-1:0]                 job_count_reg, job_count_next;
    logic [npps_pkg::MAX_JOBS-1:0] done_mask_reg, done_mask_next;
    logic [TW-1:0]                 cur_time_reg, cur_time_next;
    logic [CW-1:0]                 scan_idx_reg, scan_idx_next;
    logic [CW-1:0]                 emit_cnt_reg, emit_cnt_next;
    logic                          eval_vld_reg, eval_vld_next;
    logic [IW-1:0]                 eval_idx_reg, eval_idx_next;
    logic                          first_reg, first_next;

    logic                          found_reg, found_next;
    logic [IW-1:0]                 best_idx_reg, best_idx_next;
    npps_pkg::job_entry_t          best_reg, best_next;
    logic                          mfound_reg, mfound_next;
    logic [IW-1:0]                 min_idx_reg, min_idx_next;
    npps_pkg::job_entry_t          min_reg, min_next;

    logic                          out_valid_reg, out_valid_next;
    logic [npps_pkg::ID_W-1:0]     out_id_reg, out_id_next;
    logic [TW-1:0]                 out_start_reg, out_start_next;
    logic [TW-1:0]                 out_finish_reg, out_finish_next;
    logic [TW-1:0]                 out_turn_reg, out_turn_next;
    logic [TW-1:0]                 out_wait_reg, out_wait_next;
    logic                          out_last_reg, out_last_next;

    npps_pkg::mem_req_t            mem_req;
    npps_pkg::job_entry_t          rd_data;

    logic                          job_take;
    logic                          out_free;
    logic                          issuing;
    logic                          arrived;
    logic                          sel_found;
    logic [IW-1:0]                 sel_idx;
    npps_pkg::job_entry_t          sel_job;
    logic [TW-1:0]                 start_t;
    logic [TW:0]                   finish_sum;
    logic [TW-1:0]                 finish_t;
    logic [TW-1:0]                 sel_arr_ext;
    logic                          emit_last;

    npps_job_mem u_job_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign job.ready              = (state_reg == ST_LOAD);
    assign job_take               = job.valid && job.ready;
    assign out_free               = !out_valid_reg || result.ready;
    assign issuing                = (state_reg == ST_SCAN) && (scan_idx_reg < job_count_reg);

    assign result.valid           = out_valid_reg;
    assign result.job_id          = out_id_reg;
    assign result.start_time      = out_start_reg;
    assign result.finish_time     = out_finish_reg;
    assign result.turnaround_time = out_turn_reg;
    assign result.waiting_time    = out_wait_reg;
    assign result.last_result     = out_last_reg;

    always_comb
    begin
        mem_req.wr_en           = job_take && (job_count_reg < CW'(npps_pkg::MAX_JOBS));
        mem_req.wr_addr         = job_count_reg[IW-1:0];
        mem_req.wr_data.arrival = job.arrival_time;
        mem_req.wr_data.burst   = job.burst_time;
        mem_req.wr_data.prio    = job.job_priority;
        mem_req.rd_addr         = scan_idx_reg[IW-1:0];
    end

    // selection and timing of the chosen job
    always_comb
    begin
        sel_found   = found_reg && !first_reg;
        sel_idx     = sel_found ? best_idx_reg : min_idx_reg;
        sel_job     = sel_found ? best_reg : min_reg;
        sel_arr_ext = TW'(sel_job.arrival);
        start_t     = sel_found ? cur_time_reg : sel_arr_ext;
        finish_sum  = {1'b0, start_t} + (TW + 1)'(sel_job.burst);
        finish_t    = finish_sum[TW] ? npps_pkg::TIME_MAX : finish_sum[TW-1:0];
        emit_last   = ((emit_cnt_reg + CW'(1)) == job_count_reg);
        arrived     = !first_reg && (TW'(rd_data.arrival) <= cur_time_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        prio_mode_next  = prio_mode_reg;
        run_mode_next   = run_mode_reg;
        job_count_next  = job_count_reg;
        done_mask_next  = done_mask_reg;
        cur_time_next   = cur_time_reg;
        scan_idx_next   = scan_idx_reg;
        emit_cnt_next   = emit_cnt_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = scan_idx_reg[IW-1:0];
        first_next      = first_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        mfound_next     = mfound_reg;
        min_idx_next    = min_idx_reg;
        min_next        = min_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_id_next     = out_id_reg;
        out_start_next  = out_start_reg;
        out_finish_next = out_finish_reg;
        out_turn_next   = out_turn_reg;
        out_wait_next   = out_wait_reg;
        out_last_next   = out_last_reg;

        if (cfg_write_en)
        begin
            prio_mode_next = cfg_write_data;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (job_take)
                begin
                    if (mem_req.wr_en)
                    begin
                        job_count_next = job_count_reg + CW'(1);
                    end
                    if (job.last_job)
                    begin
                        state_next    = ST_SCAN;
                        run_mode_next = prio_mode_reg;
                        scan_idx_next = '0;
                        emit_cnt_next = '0;
                        first_next    = 1'b1;
                        found_next    = 1'b0;
                        mfound_next   = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    eval_vld_next = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (eval_vld_reg && !done_mask_reg[eval_idx_reg])
                begin
                    // arrived candidates
                    if (arrived && (!found_reg
                        || npps_pkg::prio_wins(rd_data.prio, best_reg.prio, run_mode_reg)
                        || ((rd_data.prio == best_reg.prio)
                            && (rd_data.arrival < best_reg.arrival))))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = eval_idx_reg;
                        best_next     = rd_data;
                    end
                    // earliest pending arrival group
                    if (!mfound_reg || (rd_data.arrival < min_reg.arrival)
                        || ((rd_data.arrival == min_reg.arrival)
                            && npps_pkg::prio_wins(rd_data.prio, min_reg.prio,
                                                   run_mode_reg)))
                    begin
                        mfound_next  = 1'b1;
                        min_idx_next = eval_idx_reg;
                        min_next     = rd_data;
                    end
                end
                if (!issuing && !eval_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = npps_pkg::ID_W'(sel_idx) + npps_pkg::ID_W'(1);
                    out_start_next  = start_t;
                    out_finish_next = finish_t;
                    out_turn_next   = finish_t - sel_arr_ext;
                    out_wait_next   = start_t - sel_arr_ext;
                    out_last_next   = emit_last;
                    cur_time_next   = finish_t;
                    emit_cnt_next   = emit_cnt_reg + CW'(1);
                    first_next      = 1'b0;
                    found_next      = 1'b0;
                    mfound_next     = 1'b0;
                    scan_idx_next   = '0;
                    if (emit_last)
                    begin
                        state_next     = ST_LOAD;
                        job_count_next = '0;
                        done_mask_next = '0;
                    end
                    else
                    begin
                        state_next              = ST_SCAN;
                        done_mask_next[sel_idx] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            prio_mode_reg <= npps_pkg::PRIO_MODE_LARGER;
            run_mode_reg  <= npps_pkg::PRIO_MODE_LARGER;
            job_count_reg <= '0;
            done_mask_reg <= '0;
            cur_time_reg  <= '0;
            scan_idx_reg  <= '0;
            emit_cnt_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            mfound_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prio_mode_reg <= prio_mode_next;
            run_mode_reg  <= run_mode_next;
            job_count_reg <= job_count_next;
            done_mask_reg <= done_mask_next;
            cur_time_reg  <= cur_time_next;
            scan_idx_reg  <= scan_idx_next;
            emit_cnt_reg  <= emit_cnt_next;
            eval_vld_reg  <= eval_vld_next;
            first_reg     <= first_next;
            found_reg     <= found_next;
            mfound_reg    <= mfound_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg   <= eval_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        min_idx_reg    <= min_idx_next;
        min_reg        <= min_next;
        out_id_reg     <= out_id_next;
        out_start_reg  <= out_start_next;
        out_finish_reg <= out_finish_next;
        out_turn_reg   <= out_turn_next;
        out_wait_reg   <= out_wait_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// File: rtl/npps_job_mem.sv
// job table memory, one write and one registered read per cycle
module npps_job_mem
(
    input  logic                 clk,
    input  npps_pkg::mem_req_t   req,
    output npps_pkg::job_entry_t rd_data
);

    npps_pkg::job_entry_t mem [npps_pkg::MAX_JOBS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

// File: dv/nonpreemptive_priority_scheduler_top_tb.sv
// testbench for the non-preemptive priority scheduler: directed job sets, random sets, predictor check
module nonpreemptive_priority_scheduler_top_tb;

    localparam int unsigned RANDOM_ITEMS       = 100;
    localparam int unsigned PHASE_ITEMS        = 20;
    localparam int unsigned SETTLE_CYCLES      = 40;
    localparam int unsigned RESULT_HOLD_CYCLES = 400;
    localparam int unsigned QUIET_LIMIT        = 4000;

    typedef struct packed {
        logic [npps_pkg::ARR_W-1:0]   arrival;
        logic [npps_pkg::BURST_W-1:0] burst;
        logic [npps_pkg::PRIO_W-1:0]  prio;
        logic                         last_job;
    } job_item_t;

    typedef struct packed {
        logic [npps_pkg::ID_W-1:0]   job_id;
        logic [npps_pkg::TIME_W-1:0] start_time;
        logic [npps_pkg::TIME_W-1:0] finish_time;
        logic [npps_pkg::TIME_W-1:0] turnaround_time;
        logic [npps_pkg::TIME_W-1:0] waiting_time;
        logic                        last_result;
    } sched_result_t;

    typedef struct packed {
        job_item_t     job;
        logic          typed;
        sched_result_t want;
    } directed_row_t;

    localparam sched_result_t NO_RESULT = '0;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    npps_job_if    job_ch ();
    npps_result_if result_ch ();

    nonpreemptive_priority_scheduler_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .job            (job_ch),
        .result         (result_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // predictor state
    npps_pkg::job_entry_t loaded_jobs [npps_pkg::MAX_JOBS];
    int unsigned   jobs_loaded;
    int unsigned   sched_clock;
    logic          prio_mode;
    sched_result_t pending_results [$];

    int unsigned   errors;
    int unsigned   quiet_cycles;
    bit            send_idle;
    bit            recv_idle;
    bit            hold_results;

    directed_row_t directed_jobs [] = '{
        // single-job sets
        '{'{16'd0, 16'd0, 8'd0, 1'b1}, 1'b1,
          '{7'd1, 22'd0, 22'd0, 22'd0, 22'd0, 1'b1}},
        '{'{16'hFFFF, 16'hFFFF, 8'hFF, 1'b1}, 1'b1,
          '{7'd1, 22'd65535, 22'd131070, 22'd65535, 22'd0, 1'b1}},
        '{'{16'd1234, 16'd1, 8'h80, 1'b1}, 1'b1,
          '{7'd1, 22'd1234, 22'd1235, 22'd1, 22'd0, 1'b1}},
        // equal priority, ties on arrival then id
        '{'{16'd5, 16'd4, 8'd7, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'd3, 16'd2, 8'd7, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'd3, 16'd6, 8'd7, 1'b1}, 1'b0, NO_RESULT},
        // idle gaps, clock jumps to next arrival
        '{'{16'd100, 16'd5, 8'd1, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'd500, 16'd10, 8'd9, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'd50, 16'd20, 8'd0, 1'b1}, 1'b0, NO_RESULT},
        // priority extremes, zero burst
        '{'{16'd10, 16'd3, 8'd0, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'd10, 16'd0, 8'd255, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'd10, 16'd8, 8'd128, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'd10, 16'd2, 8'd255, 1'b1}, 1'b0, NO_RESULT},
        // extreme arrivals and bursts
        '{'{16'd0, 16'hFFFF, 8'd0, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'hFFFF, 16'hFFFF, 8'd255, 1'b0}, 1'b0, NO_RESULT},
        '{'{16'd1, 16'd0, 8'd255, 1'b1}, 1'b0, NO_RESULT}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic void predict_job(input job_item_t it);
        int unsigned   n;
        int unsigned   k;
        int unsigned   i;
        int unsigned   best;
        int unsigned   next_arr;
        int unsigned   pass;
        int unsigned   fin;
        bit            found;
        bit            better;
        bit [npps_pkg::MAX_JOBS-1:0] done;
        sched_result_t r;
        if (jobs_loaded < npps_pkg::MAX_JOBS)
        begin
            loaded_jobs[jobs_loaded].arrival = it.arrival;
            loaded_jobs[jobs_loaded].burst   = it.burst;
            loaded_jobs[jobs_loaded].prio    = it.prio;
            jobs_loaded++;
        end
        if (!it.last_job)
        begin
            return;
        end
        n = jobs_loaded;
        done = '0;
        sched_clock = npps_pkg::TIME_MAX;
        for (i = 0; i < n; i++)
        begin
            if (loaded_jobs[i].arrival < sched_clock)
            begin
                sched_clock = loaded_jobs[i].arrival;
            end
        end
        for (k = 0; k < n; k++)
        begin
            found = 1'b0;
            best = 0;
            next_arr = npps_pkg::TIME_MAX;
            for (pass = 0; pass < 2 && !found; pass++)
            begin
                if (pass == 1)
                begin
                    sched_clock = next_arr;
                end
                for (i = 0; i < n; i++)
                begin
                    if (!done[i])
                    begin
                        if (loaded_jobs[i].arrival < next_arr)
                        begin
                            next_arr = loaded_jobs[i].arrival;
                        end
                        if (loaded_jobs[i].arrival <= sched_clock)
                        begin
                            if (!found)
                            begin
                                better = 1'b1;
                            end
                            else if (loaded_jobs[i].prio != loaded_jobs[best].prio)
                            begin
                                if (prio_mode == npps_pkg::PRIO_MODE_SMALLER)
                                begin
                                    better = loaded_jobs[i].prio < loaded_jobs[best].prio;
                                end
                                else
                                begin
                                    better = loaded_jobs[i].prio > loaded_jobs[best].prio;
                                end
                            end
                            else if (loaded_jobs[i].arrival != loaded_jobs[best].arrival)
                            begin
                                better = loaded_jobs[i].arrival < loaded_jobs[best].arrival;
                            end
                            else
                            begin
                                better = i < best;
                            end
                            if (better)
                            begin
                                best = i;
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
            if (!found)
            begin
                break;
            end
            fin = sched_clock + loaded_jobs[best].burst;
            if (fin > npps_pkg::TIME_MAX)
            begin
                fin = npps_pkg::TIME_MAX;
            end
            r.job_id          = npps_pkg::ID_W'(best + 1);
            r.start_time      = npps_pkg::TIME_W'(sched_clock);
            r.finish_time     = npps_pkg::TIME_W'(fin);
            r.turnaround_time = npps_pkg::TIME_W'(fin - loaded_jobs[best].arrival);
            r.waiting_time    = npps_pkg::TIME_W'(sched_clock - loaded_jobs[best].arrival);
            r.last_result     = (k + 1 == n);
            pending_results.push_back(r);
            sched_clock = fin;
            done[best] = 1'b1;
        end
        jobs_loaded = 0;
    endfunction

    task automatic send_job(input job_item_t it, input logic typed, input sched_result_t want);
        job_ch.valid        <= 1'b1;
        job_ch.arrival_time <= it.arrival;
        job_ch.burst_time   <= it.burst;
        job_ch.job_priority <= it.prio;
        job_ch.last_job     <= it.last_job;
        do @(posedge clk); while (!job_ch.ready);
        if (typed)
        begin
            pending_results.push_back(want);
        end
        else
        begin
            predict_job(it);
        end
        if (send_idle && $urandom_range(0, 2) == 0)
        begin
            job_ch.valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    task automatic send_random_set(inout int unsigned count);
        int unsigned jobs;
        int unsigned j;
        int unsigned base;
        bit          narrow_arr;
        bit          narrow_burst;
        bit          narrow_prio;
        job_item_t   it;
        case ($urandom_range(0, 9))
            0: jobs = $urandom_range(npps_pkg::MAX_JOBS + 1, npps_pkg::MAX_JOBS + 4);
            1: jobs = npps_pkg::MAX_JOBS;
            default: jobs = $urandom_range(1, 6);
        endcase
        narrow_arr   = $urandom_range(0, 3) != 0;
        narrow_burst = $urandom_range(0, 3) != 0;
        narrow_prio  = $urandom_range(0, 3) != 0;
        base = $urandom_range(0, 65535 - 64);
        for (j = 0; j < jobs; j++)
        begin
            it.arrival = narrow_arr ? npps_pkg::ARR_W'(base + $urandom_range(0, 40))
                                    : npps_pkg::ARR_W'($urandom_range(0, 65535));
            it.burst = narrow_burst ? npps_pkg::BURST_W'($urandom_range(0, 15))
                                    : npps_pkg::BURST_W'($urandom_range(0, 65535));
            it.prio = narrow_prio ? npps_pkg::PRIO_W'($urandom_range(0, 3))
                                  : npps_pkg::PRIO_W'($urandom_range(0, 255));
            // now and then a set is cut short
            it.last_job = (j == jobs - 1) || ($urandom_range(0, 24) == 0);
            send_job(it, 1'b0, NO_RESULT);
        end
        count += jobs;
    endtask

    task automatic wait_drained();
        job_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_priority_mode(input logic m);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        prio_mode = m;
        cfg_write_en <= 1'b0;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    sched_result_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual job_id %0d",
                         $time, result_ch.job_id);
                errors++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("job_id", oldest.job_id, result_ch.job_id);
                check_field("start_time", oldest.start_time, result_ch.start_time);
                check_field("finish_time", oldest.finish_time, result_ch.finish_time);
                check_field("turnaround_time", oldest.turnaround_time,
                            result_ch.turnaround_time);
                check_field("waiting_time", oldest.waiting_time, result_ch.waiting_time);
                check_field("last_result", oldest.last_result, result_ch.last_result);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((job_ch.valid && job_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAIL nonpreemptive_priority_scheduler_top");
            $finish;
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                result_ch.ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned phase_items;
        logic        mode;
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = 1'b0;
        job_ch.valid        = 1'b0;
        job_ch.arrival_time = '0;
        job_ch.burst_time   = '0;
        job_ch.job_priority = '0;
        job_ch.last_job     = 1'b0;
        errors       = 0;
        quiet_cycles = 0;
        jobs_loaded  = 0;
        sched_clock  = 0;
        prio_mode    = npps_pkg::PRIO_MODE_LARGER;
        hold_results = 1'b0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_jobs[r])
        begin
            send_job(directed_jobs[r].job, directed_jobs[r].typed, directed_jobs[r].want);
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase < 3)
            begin
                mode = (phase % 2 == 0) ? npps_pkg::PRIO_MODE_SMALLER
                                        : npps_pkg::PRIO_MODE_LARGER;
            end
            else
            begin
                mode = $urandom_range(0, 1) ? npps_pkg::PRIO_MODE_SMALLER
                                            : npps_pkg::PRIO_MODE_LARGER;
            end
            write_priority_mode(mode);
            send_idle = (phase % 3) != 1;
            recv_idle = (phase % 3) != 2;
            // output blocked while sets keep coming
            if (phase == 1)
            begin
                hold_results = 1'b1;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                send_random_set(phase_items);
            end
            sent += phase_items;
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS nonpreemptive_priority_scheduler_top");
        end
        else
        begin
            $display("FAIL nonpreemptive_priority_scheduler_top");
        end
        $finish;
    end

endmodule
